### hdl/tdsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsa_pkg
// Shared constants for the touch digitizer serial converter.
// ----------------------------------------------------------------------------
package tdsa_pkg;

    localparam int BYTE_W   = 8;
    localparam int STEP_W   = 3;               // counts the eight quotient bits
    localparam int BITS_W   = 4;               // holds 0..8 serial bits left

    localparam logic [BITS_W-1:0] XFER_BITS = 4'd8;
    localparam logic [BITS_W-1:0] LAST_BIT  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

    // action codes
    localparam logic ACT_CONVERT = 1'b0;
    localparam logic ACT_CLOCK   = 1'b1;

    // channel select codes
    localparam logic CHAN_X = 1'b0;
    localparam logic CHAN_Y = 1'b1;

endpackage

### hdl/tdsa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsa_div
// Restoring divider, one quotient bit per cycle, eight-bit quotient.
// Requires num[top] < den so the quotient fits in a byte.
// ----------------------------------------------------------------------------
module tdsa_div
    import tdsa_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SAMPLE_BITS+BYTE_W-1:0] num,
    input  logic [SAMPLE_BITS-1:0]        den,
    output logic                          done,
    output logic [BYTE_W-1:0]             quot
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [STEP_W-1:0]       cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0]  rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]  den_reg, den_next;
    logic [BYTE_W-1:0]       low_reg, low_next;
    logic [BYTE_W-1:0]       quot_reg, quot_next;

    logic [SAMPLE_BITS:0]    trial;
    logic [SAMPLE_BITS:0]    diff;
    logic                    ge;

    assign trial = {rem_reg, low_reg[BYTE_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_LAST;
            rem_next  = num[SAMPLE_BITS+BYTE_W-1:BYTE_W];
            low_next  = num[BYTE_W-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            quot_next = {quot_reg[BYTE_W-2:0], ge};
            low_next  = {low_reg[BYTE_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### hdl/touch_digitizer_serial_adc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_digitizer_serial_adc
// Serial 8-bit touch-panel converter: scales both axes, shifts bytes out.
// ----------------------------------------------------------------------------
// Convert beat: two passes through the shared 8-step divider (a prep state,
//   the divider steps and its done strobe each) give both positions.
// Serial clock beat: result fields registered on acceptance, then loaded out.
// Input stalls while a beat is in work; a finished result waits in the
//   output register while the next beat is taken.
// Reset (rst_n low, async): positions, touch flag, channel select, shifters
//   and transfer count clear; no transfer armed; output register empty.
// ----------------------------------------------------------------------------
module touch_digitizer_serial_adc
    import tdsa_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  logic [SAMPLE_BITS-1:0] x_high,
    input  logic [SAMPLE_BITS-1:0] x_low,
    input  logic [SAMPLE_BITS-1:0] x_read,
    input  logic [SAMPLE_BITS-1:0] y_high,
    input  logic [SAMPLE_BITS-1:0] y_low,
    input  logic [SAMPLE_BITS-1:0] y_read,
    input  logic                   touched,
    input  logic                   si_bit,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   sout,
    output logic                   sense_active,
    output logic [BYTE_W-1:0]      x_position,
    output logic [BYTE_W-1:0]      y_position,
    output logic [BYTE_W-1:0]      received_byte,
    output logic                   byte_done,
    output logic                   channel_select
);

    localparam int NUM_W = SAMPLE_BITS + BYTE_W;

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP_X = 3'd1;
    localparam logic [2:0] ST_DIV_X  = 3'd2;
    localparam logic [2:0] ST_PREP_Y = 3'd3;
    localparam logic [2:0] ST_DIV_Y  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]              state_reg, state_next;

    // architectural state
    logic [BYTE_W-1:0]       x_pos_reg, x_pos_next;
    logic [BYTE_W-1:0]       y_pos_reg, y_pos_next;
    logic                    touch_reg, touch_next;
    logic                    chan_reg, chan_next;
    logic [BYTE_W-1:0]       oshift_reg, oshift_next;
    logic [BYTE_W-1:0]       ishift_reg, ishift_next;
    logic [BITS_W-1:0]       bits_reg, bits_next;

    // per-beat result fields waiting for the output register
    logic                    rsout_reg, rsout_next;
    logic                    rdone_reg, rdone_next;
    logic [BYTE_W-1:0]       rbyte_reg, rbyte_next;

    // latched samples
    logic [SAMPLE_BITS-1:0]  xh_reg, xl_reg, xr_reg;
    logic [SAMPLE_BITS-1:0]  yh_reg, yl_reg, yr_reg;

    // output register
    logic                    ovalid_reg, ovalid_next;
    logic                    osout_reg, osense_reg, odone_reg, ochan_reg;
    logic [BYTE_W-1:0]       ox_reg, oy_reg, obyte_reg;

    logic                    accept;
    logic                    out_free;
    logic                    load_out;
    logic [BYTE_W-1:0]       shifted_in;

    // axis preparation: clamp and span, shared by both axes
    logic                    sel_y;
    logic [SAMPLE_BITS-1:0]  hi, lo, rd, rd_clamp, span, rd_ofs;
    logic                    degenerate;
    logic [NUM_W-1:0]        rd_ofs_ext;
    logic [NUM_W-1:0]        div_num;
    logic [SAMPLE_BITS-1:0]  div_den;
    logic                    div_start;
    logic                    div_done;
    logic [BYTE_W-1:0]       div_quot;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_free   = !ovalid_reg || !out_stall;
    assign load_out   = (state_reg == ST_FINISH) && out_free;
    assign shifted_in = {ishift_reg[BYTE_W-2:0], si_bit};

    assign sel_y      = (state_reg == ST_PREP_Y);
    assign hi         = sel_y ? yh_reg : xh_reg;
    assign lo         = sel_y ? yl_reg : xl_reg;
    assign rd         = sel_y ? yr_reg : xr_reg;
    assign degenerate = (hi <= lo);
    assign rd_clamp   = (rd < lo) ? lo : ((rd > hi) ? hi : rd);
    assign rd_ofs     = rd_clamp - lo;
    assign span       = hi - lo;
    assign rd_ofs_ext = {{BYTE_W{1'b0}}, rd_ofs};
    // offset*255 as offset*256 - offset; flat axis divides zero by one
    assign div_num    = degenerate ? '0 : ((rd_ofs_ext << BYTE_W) - rd_ofs_ext);
    assign div_den    = degenerate ? {{(SAMPLE_BITS-1){1'b0}}, 1'b1} : span;
    assign div_start  = (state_reg == ST_PREP_X) || (state_reg == ST_PREP_Y);

    tdsa_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next  = state_reg;
        x_pos_next  = x_pos_reg;
        y_pos_next  = y_pos_reg;
        touch_next  = touch_reg;
        chan_next   = chan_reg;
        oshift_next = oshift_reg;
        ishift_next = ishift_reg;
        bits_next   = bits_reg;
        rsout_next  = rsout_reg;
        rdone_next  = rdone_reg;
        rbyte_next  = rbyte_reg;
        ovalid_next = ovalid_reg;

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_CONVERT)
                    begin
                        // arm a fresh transfer, drop any in flight
                        touch_next  = touched;
                        ishift_next = '0;
                        bits_next   = XFER_BITS;
                        state_next  = ST_PREP_X;
                    end
                    else
                    begin
                        rsout_next = 1'b1;
                        rdone_next = 1'b0;
                        rbyte_next = '0;
                        if (bits_reg != '0)
                        begin
                            rsout_next  = oshift_reg[BYTE_W-1];
                            ishift_next = shifted_in;
                            oshift_next = {oshift_reg[BYTE_W-2:0], 1'b0};
                            bits_next   = bits_reg - 1'b1;
                            if (bits_reg == LAST_BIT)
                            begin
                                rdone_next = 1'b1;
                                rbyte_next = shifted_in;
                                chan_next  = si_bit;
                            end
                        end
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_PREP_X:
            begin
                state_next = ST_DIV_X;
            end
            ST_DIV_X:
            begin
                if (div_done)
                begin
                    x_pos_next = div_quot;
                    state_next = ST_PREP_Y;
                end
            end
            ST_PREP_Y:
            begin
                state_next = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                if (div_done)
                begin
                    y_pos_next  = div_quot;
                    oshift_next = (chan_reg == CHAN_Y) ? div_quot : x_pos_reg;
                    rsout_next  = (chan_reg == CHAN_Y) ? div_quot[BYTE_W-1]
                                                       : x_pos_reg[BYTE_W-1];
                    rdone_next  = 1'b0;
                    rbyte_next  = '0;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            x_pos_reg  <= '0;
            y_pos_reg  <= '0;
            touch_reg  <= 1'b0;
            chan_reg   <= CHAN_X;
            oshift_reg <= '0;
            ishift_reg <= '0;
            bits_reg   <= '0;
            rsout_reg  <= 1'b1;
            rdone_reg  <= 1'b0;
            rbyte_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            x_pos_reg  <= x_pos_next;
            y_pos_reg  <= y_pos_next;
            touch_reg  <= touch_next;
            chan_reg   <= chan_next;
            oshift_reg <= oshift_next;
            ishift_reg <= ishift_next;
            bits_reg   <= bits_next;
            rsout_reg  <= rsout_next;
            rdone_reg  <= rdone_next;
            rbyte_reg  <= rbyte_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // sample capture on convert beats
    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_CONVERT))
        begin
            xh_reg <= x_high;
            xl_reg <= x_low;
            xr_reg <= x_read;
            yh_reg <= y_high;
            yl_reg <= y_low;
            yr_reg <= y_read;
        end
    end

    // output payload snapshot
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            osout_reg  <= rsout_reg;
            osense_reg <= touch_reg;
            ox_reg     <= x_pos_reg;
            oy_reg     <= y_pos_reg;
            obyte_reg  <= rbyte_reg;
            odone_reg  <= rdone_reg;
            ochan_reg  <= chan_reg;
        end
    end

    assign out_valid      = ovalid_reg;
    assign sout           = osout_reg;
    assign sense_active   = osense_reg;
    assign x_position     = ox_reg;
    assign y_position     = oy_reg;
    assign received_byte  = obyte_reg;
    assign byte_done      = odone_reg;
    assign channel_select = ochan_reg;

endmodule

### hdl/tdsa_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsa_chk
// Port-level checks for the touch digitizer serial converter.
// ----------------------------------------------------------------------------
module tdsa_chk
    import tdsa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              sout,
    input logic              sense_active,
    input logic [BYTE_W-1:0] x_position,
    input logic [BYTE_W-1:0] y_position,
    input logic [BYTE_W-1:0] received_byte,
    input logic              byte_done,
    input logic              channel_select
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(received_byte)
            && $stable(byte_done) && $stable(x_position) && $stable(y_position)
            && $stable(sout) && $stable(sense_active) && $stable(channel_select))
        else $error("result beat changed while stalled");

    // every accepted beat leaves the input stalled in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // the completed byte's bit 0 becomes the channel select
    a_chan_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_done |-> channel_select == received_byte[0])
        else $error("channel select does not follow received byte");

    // no byte reported unless the transfer completed
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_done |-> received_byte == '0)
        else $error("received byte nonzero without completion");

endmodule

bind touch_digitizer_serial_adc tdsa_chk u_tdsa_chk (.*);
